@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_IMPLY_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ rtl/core/rrcl_pkg.sv @@
package rrcl_pkg;

	localparam int CORDIC_STEPS = 28;
	localparam int DIV_LAT      = 38;
	localparam int SQRT_LAT     = 32;

	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		coord_t offset;
		coord_t cos_v;
		coord_t sin_v;
		coord_t min_x;
		coord_t min_y;
		coord_t max_x;
		coord_t max_y;
	} rrcl_item_t;

	typedef struct packed {
		logic [31:0] len;
		logic        hit;
	} rrcl_result_t;

	typedef struct packed {
		logic hit;
		logic sat;
	} rrcl_flags_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rrcl_fifo_status_t;

	// CORDIC arctangent steps in units of 2^-32 turn
	function automatic logic [29:0] atan_turn(input logic [4:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/rrcl_fifo.sv @@
`include "assert_macros.svh"

module rrcl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [WIDTH-1:0]            din,
	input  logic                        pop,
	output logic [WIDTH-1:0]            dout,
	output rrcl_pkg::rrcl_fifo_status_t status
);
	import rrcl_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign dout         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_fifo_push_full, clk, arst_n, push && status.full)
	`ASSERT_NEVER(a_fifo_count_range, clk, arst_n, count_q > CW'(DEPTH))

endmodule

@@ rtl/core/rrcl_front.sv @@
`include "assert_macros.svh"

module rrcl_front #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_push,
	output logic                        in_full,
	input  rrcl_pkg::coord_t            ray_offset,
	input  logic [ANGLE_BITS-1:0]       ray_angle,
	input  rrcl_pkg::coord_t            box_min_x,
	input  rrcl_pkg::coord_t            box_min_y,
	input  rrcl_pkg::coord_t            box_max_x,
	input  rrcl_pkg::coord_t            box_max_y,
	input  rrcl_pkg::rrcl_fifo_status_t mid_status,
	output logic                        mid_push,
	output rrcl_pkg::rrcl_item_t        mid_item
);
	import rrcl_pkg::*;

	localparam int LAT = CORDIC_STEPS + 2;

	logic [LAT-1:0] vld_q;
	logic           adv;
	logic [31:0]    phase;

	// stage 1: quadrant split
	logic [1:0]          quad_s1;
	logic signed [31:0]  z_s1;
	logic                zero_s1;
	rrcl_item_t          item_s1;

	// CORDIC stages, index = iterations done
	logic signed [33:0]  x_s    [1:CORDIC_STEPS];
	logic signed [33:0]  y_s    [1:CORDIC_STEPS];
	logic signed [31:0]  z_s    [1:CORDIC_STEPS];
	logic [1:0]          quad_s [1:CORDIC_STEPS];
	logic                zero_s [1:CORDIC_STEPS];
	rrcl_item_t          item_s [1:CORDIC_STEPS];

	rrcl_item_t          item_s30;
	logic signed [33:0]  xf, yf, cf, sf;

	assign adv      = !vld_q[LAT-1] || !mid_status.full;
	assign in_full  = !adv;
	assign mid_push = vld_q[LAT-1] && !mid_status.full;
	assign mid_item = item_s30;
	assign phase    = {ray_angle, {(32 - ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_push};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quad_s1 <= phase[31:30] + {1'b0, phase[29]};
			z_s1    <= {{2{phase[29]}}, phase[29:0]};
			zero_s1 <= (phase[29:0] == '0);
			item_s1 <= '{offset: ray_offset, cos_v: '0, sin_v: '0,
				min_x: box_min_x, min_y: box_min_y,
				max_x: box_max_x, max_y: box_max_y};
		end
	end

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		logic signed [33:0] xi, yi, dx, dy;
		logic signed [31:0] zi, at;
		logic [1:0]         qi;
		logic               zri;
		rrcl_item_t         iti;

		if (g == 0) begin : g_head
			assign xi  = GAIN_Q30;
			assign yi  = '0;
			assign zi  = z_s1;
			assign qi  = quad_s1;
			assign zri = zero_s1;
			assign iti = item_s1;
		end else begin : g_body
			assign xi  = x_s[g];
			assign yi  = y_s[g];
			assign zi  = z_s[g];
			assign qi  = quad_s[g];
			assign zri = zero_s[g];
			assign iti = item_s[g];
		end

		assign dx = yi >>> g;
		assign dy = xi >>> g;
		assign at = $signed({2'b00, atan_turn(5'(g))});

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!zi[31]) begin
					x_s[g+1] <= xi - dx;
					y_s[g+1] <= yi + dy;
					z_s[g+1] <= zi - at;
				end else begin
					x_s[g+1] <= xi + dx;
					y_s[g+1] <= yi - dy;
					z_s[g+1] <= zi + at;
				end
				quad_s[g+1] <= qi;
				zero_s[g+1] <= zri;
				item_s[g+1] <= iti;
			end
		end
	end

	// exact quadrant angles bypass the rotation error
	always_comb begin
		xf = zero_s[CORDIC_STEPS] ? ONE_Q30 : x_s[CORDIC_STEPS];
		yf = zero_s[CORDIC_STEPS] ? '0 : y_s[CORDIC_STEPS];
		unique case (quad_s[CORDIC_STEPS])
			2'd0: begin cf = xf;  sf = yf;  end
			2'd1: begin cf = -yf; sf = xf;  end
			2'd2: begin cf = -xf; sf = -yf; end
			default: begin cf = yf; sf = -xf; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s30 <= '{offset: item_s[CORDIC_STEPS].offset,
				cos_v: cf[31:0], sin_v: sf[31:0],
				min_x: item_s[CORDIC_STEPS].min_x, min_y: item_s[CORDIC_STEPS].min_y,
				max_x: item_s[CORDIC_STEPS].max_x, max_y: item_s[CORDIC_STEPS].max_y};
		end
	end

	`ASSERT_IMPLY_NEXT(a_front_hold, clk, arst_n, vld_q[LAT-1] && mid_status.full, vld_q[LAT-1])

endmodule

@@ rtl/core/rrcl_div_lane.sv @@
module rrcl_div_lane (
	input  logic             clk,
	input  logic             en,
	input  rrcl_pkg::coord_t offset,
	input  rrcl_pkg::coord_t coord,
	input  rrcl_pkg::coord_t tmul,
	input  rrcl_pkg::coord_t tdiv,
	input  rrcl_pkg::coord_t span_lo,
	input  rrcl_pkg::coord_t span_hi,
	output logic             ok,
	output rrcl_pkg::coord_t cross_val,
	output rrcl_pkg::coord_t fixed
);
	import rrcl_pkg::*;

	typedef struct packed {
		logic [31:0] dabs;
		logic        neg;
		logic        bad;
		coord_t      lo;
		coord_t      hi;
		coord_t      fix;
	} side_t;

	logic signed [63:0] prod_s1;
	coord_t             off_s1, den_s1, lo_s1, hi_s1, fix_s1;
	logic signed [63:0] num_s2;
	coord_t             den_s2, lo_s2, hi_s2, fix_s2;
	logic [62:0]        nabs_s3;
	logic [31:0]        dabs_s3;
	logic               neg_s3, dz_s3;
	coord_t             lo_s3, hi_s3, fix_s3;
	logic [31:0]        rem_s4, low_s4;
	side_t              side_s4;

	logic [31:0]        rem_s  [1:32];
	logic [31:0]        low_s  [1:32];
	logic [31:0]        quo_s  [1:32];
	side_t              side_s [1:32];

	logic signed [32:0] val_s37;
	side_t              side_s37;
	logic               ok_s38;
	coord_t             cross_s38, fixed_s38;

	assign ok        = ok_s38;
	assign cross_val = cross_s38;
	assign fixed     = fixed_s38;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 64'(coord) * 64'(tmul);
			off_s1  <= offset;
			den_s1  <= tdiv;
			lo_s1   <= span_lo;
			hi_s1   <= span_hi;
			fix_s1  <= coord;

			num_s2  <= $signed({{2{off_s1[31]}}, off_s1, 30'd0}) - prod_s1;
			den_s2  <= den_s1;
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
			fix_s2  <= fix_s1;

			nabs_s3 <= num_s2[63] ? 63'(-num_s2) : num_s2[62:0];
			dabs_s3 <= den_s2[31] ? 32'(-den_s2) : 32'(den_s2);
			neg_s3  <= num_s2[63] ^ den_s2[31];
			dz_s3   <= (den_s2 == '0);
			lo_s3   <= lo_s2;
			hi_s3   <= hi_s2;
			fix_s3  <= fix_s2;

			// quotient needs more than 32 bits or divisor is zero: cannot land on a 32-bit edge
			rem_s4  <= {1'b0, nabs_s3[62:32]};
			low_s4  <= nabs_s3[31:0];
			side_s4 <= '{dabs: dabs_s3, neg: neg_s3,
				bad: dz_s3 || ({1'b0, nabs_s3[62:32]} >= dabs_s3),
				lo: lo_s3, hi: hi_s3, fix: fix_s3};
		end
	end

	for (genvar g = 0; g < 32; g++) begin : g_div
		logic [31:0] ri, li, qi;
		side_t       si;
		logic [32:0] sh, diff;
		logic        ge;

		if (g == 0) begin : g_head
			assign ri = rem_s4;
			assign li = low_s4;
			assign qi = '0;
			assign si = side_s4;
		end else begin : g_body
			assign ri = rem_s[g];
			assign li = low_s[g];
			assign qi = quo_s[g];
			assign si = side_s[g];
		end

		assign sh   = {ri, li[31]};
		assign diff = sh - {1'b0, si.dabs};
		assign ge   = (sh >= {1'b0, si.dabs});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= ge ? diff[31:0] : sh[31:0];
				low_s[g+1]  <= {li[30:0], 1'b0};
				quo_s[g+1]  <= {qi[30:0], ge};
				side_s[g+1] <= si;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s37   <= side_s[32].neg ? $signed(-{1'b0, quo_s[32]})
				: $signed({1'b0, quo_s[32]});
			side_s37  <= side_s[32];

			ok_s38    <= !side_s37.bad && (val_s37 >= 33'(side_s37.lo))
				&& (val_s37 <= 33'(side_s37.hi));
			cross_s38 <= val_s37[31:0];
			fixed_s38 <= side_s37.fix;
		end
	end

endmodule

@@ rtl/core/rrcl_isqrt.sv @@
module rrcl_isqrt (
	input  logic                  clk,
	input  logic                  en,
	input  logic [63:0]           v,
	input  rrcl_pkg::rrcl_flags_t flags_in,
	output logic [31:0]           root,
	output rrcl_pkg::rrcl_flags_t flags_out
);
	import rrcl_pkg::*;

	logic [33:0]  rem_s [1:SQRT_LAT];
	logic [31:0]  rt_s  [1:SQRT_LAT];
	logic [63:0]  opd_s [1:SQRT_LAT];
	rrcl_flags_t  fl_s  [1:SQRT_LAT];

	assign root      = rt_s[SQRT_LAT];
	assign flags_out = fl_s[SQRT_LAT];

	// one result bit per stage, two operand bits brought down each time
	for (genvar g = 0; g < SQRT_LAT; g++) begin : g_root
		logic [33:0] ri;
		logic [31:0] ti;
		logic [63:0] oi;
		rrcl_flags_t fi;
		logic [35:0] sh, trial;

		if (g == 0) begin : g_head
			assign ri = '0;
			assign ti = '0;
			assign oi = v;
			assign fi = flags_in;
		end else begin : g_body
			assign ri = rem_s[g];
			assign ti = rt_s[g];
			assign oi = opd_s[g];
			assign fi = fl_s[g];
		end

		assign sh    = {ri, oi[63:62]};
		assign trial = {2'b00, ti, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (sh >= trial) begin
					rem_s[g+1] <= 34'(sh - trial);
					rt_s[g+1]  <= {ti[30:0], 1'b1};
				end else begin
					rem_s[g+1] <= sh[33:0];
					rt_s[g+1]  <= {ti[30:0], 1'b0};
				end
				opd_s[g+1] <= {oi[61:0], 2'b00};
				fl_s[g+1]  <= fi;
			end
		end
	end

endmodule

@@ rtl/core/rrcl_back.sv @@
`include "assert_macros.svh"

module rrcl_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rrcl_pkg::rrcl_item_t        mid_item,
	input  rrcl_pkg::rrcl_fifo_status_t mid_status,
	output logic                        mid_pop,
	output rrcl_pkg::rrcl_result_t      res,
	output logic                        res_push,
	input  rrcl_pkg::rrcl_fifo_status_t res_status
);
	import rrcl_pkg::*;

	localparam int BACK_LAT = DIV_LAT + 4 + SQRT_LAT + 1;

	logic [BACK_LAT-1:0] vld_q;
	logic                adv;

	logic [3:0]          ok;
	coord_t              cross_val [4];
	coord_t              fixed [4];
	coord_t              px [4];
	coord_t              py [4];
	logic [1:0]          ia, ib;
	logic                fa, fb;

	logic signed [32:0]  dx_s39, dy_s39;
	logic                hit_s39;
	logic [31:0]         ux_s40, uy_s40;
	logic                hit_s40;
	logic [63:0]         sx_s41, sy_s41;
	logic                hit_s41;
	logic [64:0]         sum;
	logic [63:0]         tot_s42;
	rrcl_flags_t         flags_s42;
	logic [31:0]         root;
	rrcl_flags_t         flags_root;
	rrcl_result_t        res_s75;

	assign adv      = !vld_q[BACK_LAT-1] || !res_status.full;
	assign mid_pop  = adv && !mid_status.empty;
	assign res_push = vld_q[BACK_LAT-1] && !res_status.full;
	assign res      = res_s75;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[BACK_LAT-2:0], !mid_status.empty};
		end
	end

	// crossings with left, right, bottom, top sides
	rrcl_div_lane u_left (
		.clk(clk), .en(adv), .offset(mid_item.offset), .coord(mid_item.min_x),
		.tmul(mid_item.cos_v), .tdiv(mid_item.sin_v),
		.span_lo(mid_item.min_y), .span_hi(mid_item.max_y),
		.ok(ok[0]), .cross_val(cross_val[0]), .fixed(fixed[0])
	);
	rrcl_div_lane u_right (
		.clk(clk), .en(adv), .offset(mid_item.offset), .coord(mid_item.max_x),
		.tmul(mid_item.cos_v), .tdiv(mid_item.sin_v),
		.span_lo(mid_item.min_y), .span_hi(mid_item.max_y),
		.ok(ok[1]), .cross_val(cross_val[1]), .fixed(fixed[1])
	);
	rrcl_div_lane u_bottom (
		.clk(clk), .en(adv), .offset(mid_item.offset), .coord(mid_item.min_y),
		.tmul(mid_item.sin_v), .tdiv(mid_item.cos_v),
		.span_lo(mid_item.min_x), .span_hi(mid_item.max_x),
		.ok(ok[2]), .cross_val(cross_val[2]), .fixed(fixed[2])
	);
	rrcl_div_lane u_top (
		.clk(clk), .en(adv), .offset(mid_item.offset), .coord(mid_item.max_y),
		.tmul(mid_item.sin_v), .tdiv(mid_item.cos_v),
		.span_lo(mid_item.min_x), .span_hi(mid_item.max_x),
		.ok(ok[3]), .cross_val(cross_val[3]), .fixed(fixed[3])
	);

	// take the first two crossings in side order
	always_comb begin
		px[0] = fixed[0]; py[0] = cross_val[0];
		px[1] = fixed[1]; py[1] = cross_val[1];
		px[2] = cross_val[2]; py[2] = fixed[2];
		px[3] = cross_val[3]; py[3] = fixed[3];
		fa = 1'b0;
		fb = 1'b0;
		ia = '0;
		ib = '0;
		for (int k = 0; k < 4; k++) begin
			if (ok[k]) begin
				if (!fa) begin
					fa = 1'b1;
					ia = 2'(k);
				end else if (!fb) begin
					fb = 1'b1;
					ib = 2'(k);
				end
			end
		end
	end

	assign sum = {1'b0, sx_s41} + {1'b0, sy_s41};

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s39    <= 33'(px[ib]) - 33'(px[ia]);
			dy_s39    <= 33'(py[ib]) - 33'(py[ia]);
			hit_s39   <= fb;

			ux_s40    <= dx_s39[32] ? 32'(-dx_s39) : dx_s39[31:0];
			uy_s40    <= dy_s39[32] ? 32'(-dy_s39) : dy_s39[31:0];
			hit_s40   <= hit_s39;

			sx_s41    <= 64'(ux_s40) * 64'(ux_s40);
			sy_s41    <= 64'(uy_s40) * 64'(uy_s40);
			hit_s41   <= hit_s40;

			tot_s42   <= sum[63:0];
			flags_s42 <= '{hit: hit_s41, sat: sum[64]};
		end
	end

	rrcl_isqrt u_isqrt (
		.clk(clk), .en(adv), .v(tot_s42), .flags_in(flags_s42),
		.root(root), .flags_out(flags_root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s75.hit <= flags_root.hit;
			if (!flags_root.hit) begin
				res_s75.len <= '0;
			end else if (flags_root.sat) begin
				res_s75.len <= '1;
			end else begin
				res_s75.len <= root;
			end
		end
	end

	`ASSERT_NEVER(a_miss_zero_len, clk, arst_n, res_push && !res.hit && (res.len != '0))

endmodule

@@ rtl/core/ray_rectangle_chord_length_core.sv @@
// Path: a transaction passes the front, the middle queue, the back and the result queue,
//   from which pop can take the result; back-pressure can stall it on the way.
// Throughput: one transaction per cycle while no back-pressure stalls; the 28-step CORDIC,
//   four 32-stage dividers and the 32-stage square root are all fully pipelined.
// Reset: arst_n clears the valid bits, queue pointers and queue counts; no other state is kept.
module ray_rectangle_chord_length_core #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic signed [31:0]     ray_offset,
	input  logic [ANGLE_BITS-1:0]  ray_angle,
	input  logic signed [31:0]     box_min_x,
	input  logic signed [31:0]     box_min_y,
	input  logic signed [31:0]     box_max_x,
	input  logic signed [31:0]     box_max_y,
	output logic                   empty,
	input  logic                   pop,
	output logic [31:0]            chord_length,
	output logic                   hit
);
	import rrcl_pkg::*;

	localparam int ITEM_W = $bits(rrcl_item_t);
	localparam int RES_W  = $bits(rrcl_result_t);

	logic              mid_push, mid_pop, res_push;
	rrcl_item_t        mid_in, mid_out;
	logic [ITEM_W-1:0] mid_dout;
	rrcl_fifo_status_t mid_status, res_status;
	rrcl_result_t      res_in, res_out;
	logic [RES_W-1:0]  res_dout;

	rrcl_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_push(push), .in_full(full),
		.ray_offset(ray_offset), .ray_angle(ray_angle),
		.box_min_x(box_min_x), .box_min_y(box_min_y),
		.box_max_x(box_max_x), .box_max_y(box_max_y),
		.mid_status(mid_status), .mid_push(mid_push), .mid_item(mid_in)
	);

	rrcl_fifo #(.WIDTH(ITEM_W), .DEPTH(4)) u_mid_fifo (
		.clk(clk), .arst_n(arst_n), .push(mid_push), .din(mid_in),
		.pop(mid_pop), .dout(mid_dout), .status(mid_status)
	);

	assign mid_out = rrcl_item_t'(mid_dout);

	rrcl_back u_back (
		.clk(clk), .arst_n(arst_n), .mid_item(mid_out), .mid_status(mid_status),
		.mid_pop(mid_pop), .res(res_in), .res_push(res_push), .res_status(res_status)
	);

	rrcl_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_fifo (
		.clk(clk), .arst_n(arst_n), .push(res_push), .din(res_in),
		.pop(pop), .dout(res_dout), .status(res_status)
	);

	assign res_out      = rrcl_result_t'(res_dout);
	assign empty        = res_status.empty;
	assign chord_length = res_out.len;
	assign hit          = res_out.hit;

endmodule
